[sv/lcbc_pkg.sv]
// shared types and constants for the card number check block
// no dependencies

package lcbc_pkg;

  // width of the binary card number
  localparam int unsigned DATA_W = 63;
  // input tdata width, rounded up to whole bytes
  localparam int unsigned IN_TDATA_W = 64;
  // default number of decimal digits examined
  localparam int unsigned MAX_DIGITS_DEF = 19;
  // digit count width
  localparam int unsigned CNT_W = 5;
  // width of one bcd digit
  localparam int unsigned DIG_W = 4;
  // output tdata width: brand, luhn flag, digit count
  localparam int unsigned OUT_TDATA_W = 8;

  typedef enum logic [1:0] {
    BRAND_NONE    = 2'd0,
    BRAND_FIFTEEN = 2'd1,
    BRAND_LEAD4   = 2'd2,
    BRAND_LEAD5   = 2'd3
  } brand_e;

  // running state of the digit scan, handed from cell to cell
  typedef struct packed {
    logic               found;    // leading digit seen
    logic               need_lo;  // next digit is the second leading digit
    logic [CNT_W-1:0]   count;    // significant digit count
    logic [DIG_W-1:0]   hi;       // leading digit
    logic [DIG_W-1:0]   lo;       // second leading digit
    logic [DIG_W-1:0]   sum;      // luhn sum mod 10
  } scan_t;

  typedef struct packed {
    logic [CNT_W-1:0] digit_count;
    logic             luhn_ok;
    brand_e           brand;
  } result_t;

endpackage

[sv/lcbc_dabble_cell.sv]
// one shift-and-add-3 step of the binary to bcd conversion
// depends on lcbc_pkg

module lcbc_dabble_cell #(
  parameter int unsigned MAX_DIGITS = lcbc_pkg::MAX_DIGITS_DEF
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      en_i,
  input  logic                                      valid_i,
  input  logic [lcbc_pkg::DATA_W-1:0]               bin_i,
  input  logic [MAX_DIGITS*lcbc_pkg::DIG_W-1:0]     bcd_i,
  input  logic                                      ovf_i,
  output logic                                      valid_o,
  output logic [lcbc_pkg::DATA_W-1:0]               bin_o,
  output logic [MAX_DIGITS*lcbc_pkg::DIG_W-1:0]     bcd_o,
  output logic                                      ovf_o
);

  localparam int unsigned BcdW = MAX_DIGITS * lcbc_pkg::DIG_W;

  logic                           valid_q;
  logic [lcbc_pkg::DATA_W-1:0]    bin_q, bin_d;
  logic [BcdW-1:0]                bcd_q, bcd_d;
  logic                           ovf_q, ovf_d;
  logic [BcdW-1:0]                corr;

  // add 3 to every digit of 5 or more, all digits in parallel
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (bcd_i[i*lcbc_pkg::DIG_W +: lcbc_pkg::DIG_W] >= 4'd5) begin
        corr[i*lcbc_pkg::DIG_W +: lcbc_pkg::DIG_W] =
          bcd_i[i*lcbc_pkg::DIG_W +: lcbc_pkg::DIG_W] + 4'd3;
      end else begin
        corr[i*lcbc_pkg::DIG_W +: lcbc_pkg::DIG_W] =
          bcd_i[i*lcbc_pkg::DIG_W +: lcbc_pkg::DIG_W];
      end
    end
    bcd_d = {corr[BcdW-2:0], bin_i[lcbc_pkg::DATA_W-1]};
    bin_d = {bin_i[lcbc_pkg::DATA_W-2:0], 1'b0};
    // a bit carried out of the top digit means more digits than examined
    ovf_d = ovf_i | corr[BcdW-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bin_q <= bin_d;
      bcd_q <= bcd_d;
      ovf_q <= ovf_d;
    end
  end

  assign valid_o = valid_q;
  assign bin_o   = bin_q;
  assign bcd_o   = bcd_q;
  assign ovf_o   = ovf_q;

endmodule

[sv/lcbc_scan_cell.sv]
// one digit position of the luhn sum and leading digit search
// depends on lcbc_pkg

module lcbc_scan_cell #(
  parameter int unsigned MAX_DIGITS = lcbc_pkg::MAX_DIGITS_DEF,
  parameter int unsigned POS        = 0
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      en_i,
  input  logic                                      valid_i,
  input  logic [MAX_DIGITS*lcbc_pkg::DIG_W-1:0]     bcd_i,
  input  logic                                      ovf_i,
  input  lcbc_pkg::scan_t                           scan_i,
  output logic                                      valid_o,
  output logic [MAX_DIGITS*lcbc_pkg::DIG_W-1:0]     bcd_o,
  output logic                                      ovf_o,
  output lcbc_pkg::scan_t                           scan_o
);

  localparam int unsigned BcdW   = MAX_DIGITS * lcbc_pkg::DIG_W;
  localparam bit          IsTop  = (POS == MAX_DIGITS - 1);
  localparam bit          IsOdd  = (POS % 2 == 1);
  localparam logic [lcbc_pkg::CNT_W-1:0] PosCount = lcbc_pkg::CNT_W'(POS + 1);

  logic                        valid_q;
  logic [BcdW-1:0]             bcd_q;
  logic                        ovf_q;
  lcbc_pkg::scan_t             scan_q, scan_d;
  logic [lcbc_pkg::DIG_W-1:0]  dig;
  logic [lcbc_pkg::DIG_W:0]    term;
  logic [lcbc_pkg::DIG_W:0]    acc;
  logic                        lead_here;

  always_comb begin
    dig  = bcd_i[POS*lcbc_pkg::DIG_W +: lcbc_pkg::DIG_W];
    term = {1'b0, dig};
    // doubled position: 2d, minus 9 when two digits
    if (IsOdd) begin
      term = {dig, 1'b0};
      if (term >= 5'd10) begin
        term = term - 5'd9;
      end
    end
    acc = {1'b0, scan_i.sum} + term;
    if (acc >= 5'd10) begin
      acc = acc - 5'd10;
    end
    // on overflow the top examined position counts as leading
    lead_here = !scan_i.found && ((dig != '0) || (IsTop && ovf_i));

    scan_d     = scan_i;
    scan_d.sum = acc[lcbc_pkg::DIG_W-1:0];
    if (lead_here) begin
      scan_d.found   = 1'b1;
      scan_d.need_lo = 1'b1;
      scan_d.count   = PosCount;
      scan_d.hi      = dig;
    end else if (scan_i.need_lo) begin
      scan_d.need_lo = 1'b0;
      scan_d.lo      = dig;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bcd_q  <= bcd_i;
      ovf_q  <= ovf_i;
      scan_q <= scan_d;
    end
  end

  assign valid_o = valid_q;
  assign bcd_o   = bcd_q;
  assign ovf_o   = ovf_q;
  assign scan_o  = scan_q;

endmodule

[sv/lcbc_skid.sv]
// output register with a one-entry skid stage
// depends on lcbc_pkg

module lcbc_skid (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  lcbc_pkg::result_t in_data_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  output lcbc_pkg::result_t out_data_o,
  input  logic              out_ready_i
);

  logic              out_valid_q, out_valid_d;
  logic              skid_valid_q, skid_valid_d;
  lcbc_pkg::result_t out_data_q, out_data_d;
  lcbc_pkg::result_t skid_data_q, skid_data_d;
  logic              in_fire;
  logic              out_take;

  always_comb begin
    in_fire      = in_valid_i && !skid_valid_q;
    out_take     = out_valid_q && out_ready_i;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_data_d   = out_data_q;
    skid_data_d  = skid_data_q;
    if (skid_valid_q) begin
      if (out_take) begin
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end
    end else if (in_fire) begin
      if (!out_valid_q || out_take) begin
        out_data_d  = in_data_i;
        out_valid_d = 1'b1;
      end else begin
        skid_data_d  = in_data_i;
        skid_valid_d = 1'b1;
      end
    end else if (out_take) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign in_ready_o  = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

[sv/luhn_card_brand_check.sv]
// top level of the luhn mod-10 card number check with brand code
// depends on lcbc_pkg, lcbc_dabble_cell, lcbc_scan_cell, lcbc_skid
//
// channel   dir  tdata bits (lowest first)                        tuser  tlast
// s_axis    in   [62:0] card_number, [63] zero                    -      -
// m_axis    out  [1:0] brand, [2] luhn_ok, [7:3] digit_count      -      -
//
// one item per cycle while the skid stage is empty; the path runs through the row of
// 63 shift-and-add-3 cells (one per input bit) followed by one scan cell per
// decimal digit and the output register
// reset clears only the valid bits of the cells and the output stage
// the whole row moves as one while the skid stage is empty; a stalled result
// parks in the skid stage and the row freezes until it drains

module luhn_card_brand_check #(
  parameter int unsigned MAX_DIGITS = lcbc_pkg::MAX_DIGITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [lcbc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,   // [62:0] card_number
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [lcbc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata    // brand, luhn_ok, digit_count
);

  localparam int unsigned DataW = lcbc_pkg::DATA_W;
  localparam int unsigned BcdW  = MAX_DIGITS * lcbc_pkg::DIG_W;

  // row advance: whole pipeline moves while the skid stage has room
  logic en;

  // binary to bcd row, stage 0 is the input
  logic             dab_valid [0:DataW];
  logic [DataW-1:0] dab_bin   [0:DataW];
  logic [BcdW-1:0]  dab_bcd   [0:DataW];
  logic             dab_ovf   [0:DataW];

  // digit scan row, most significant examined digit first
  logic             scn_valid [0:MAX_DIGITS];
  logic [BcdW-1:0]  scn_bcd   [0:MAX_DIGITS];
  logic             scn_ovf   [0:MAX_DIGITS];
  lcbc_pkg::scan_t  scn_state [0:MAX_DIGITS];

  lcbc_pkg::scan_t   fin;
  lcbc_pkg::result_t res;
  lcbc_pkg::result_t out_res;
  logic              luhn_ok;

  assign s_axis_tready = en;

  assign dab_valid[0] = s_axis_tvalid;
  assign dab_bin[0]   = s_axis_tdata[DataW-1:0];
  assign dab_bcd[0]   = '0;
  assign dab_ovf[0]   = 1'b0;

  for (genvar g = 0; g < DataW; g++) begin : g_dabble
    lcbc_dabble_cell #(
      .MAX_DIGITS (MAX_DIGITS)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dab_valid[g]),
      .bin_i   (dab_bin[g]),
      .bcd_i   (dab_bcd[g]),
      .ovf_i   (dab_ovf[g]),
      .valid_o (dab_valid[g+1]),
      .bin_o   (dab_bin[g+1]),
      .bcd_o   (dab_bcd[g+1]),
      .ovf_o   (dab_ovf[g+1])
    );
  end

  // scan starts empty: no digit found, luhn sum zero
  assign scn_valid[0] = dab_valid[DataW];
  assign scn_bcd[0]   = dab_bcd[DataW];
  assign scn_ovf[0]   = dab_ovf[DataW];
  assign scn_state[0] = '0;

  for (genvar g = 0; g < MAX_DIGITS; g++) begin : g_scan
    lcbc_scan_cell #(
      .MAX_DIGITS (MAX_DIGITS),
      .POS        (MAX_DIGITS - 1 - g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (scn_valid[g]),
      .bcd_i   (scn_bcd[g]),
      .ovf_i   (scn_ovf[g]),
      .scan_i  (scn_state[g]),
      .valid_o (scn_valid[g+1]),
      .bcd_o   (scn_bcd[g+1]),
      .ovf_o   (scn_ovf[g+1]),
      .scan_o  (scn_state[g+1])
    );
  end

  // brand from length and the two leading digits, only when luhn passes
  always_comb begin
    fin     = scn_state[MAX_DIGITS];
    luhn_ok = (fin.sum == '0);
    res     = '0;
    res.brand       = lcbc_pkg::BRAND_NONE;
    res.luhn_ok     = luhn_ok;
    res.digit_count = fin.count;
    if (luhn_ok) begin
      if (fin.count == 5'd15) begin
        if (fin.hi == 4'd3 && (fin.lo == 4'd4 || fin.lo == 4'd7)) begin
          res.brand = lcbc_pkg::BRAND_FIFTEEN;
        end
      end else if (fin.count == 5'd13 || fin.count == 5'd16) begin
        if (fin.hi == 4'd4) begin
          res.brand = lcbc_pkg::BRAND_LEAD4;
        end else if (fin.count == 5'd16 && fin.hi == 4'd5 &&
                     fin.lo >= 4'd1 && fin.lo <= 4'd5) begin
          res.brand = lcbc_pkg::BRAND_LEAD5;
        end
      end
    end
  end

  lcbc_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (scn_valid[MAX_DIGITS]),
    .in_data_i   (res),
    .in_ready_o  (en),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (out_res),
    .out_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = out_res;

endmodule

[bench/luhn_card_brand_check_tb.sv]
// self-checking bench for luhn_card_brand_check: streams card numbers, predicts
// brand, luhn flag and digit count per item and compares them in order
// depends on lcbc_pkg and the luhn_card_brand_check rtl
`timescale 1ns / 1ps

module luhn_card_brand_check_tb;

  localparam int unsigned DATA_W      = lcbc_pkg::DATA_W;
  localparam int unsigned IN_TDATA_W  = lcbc_pkg::IN_TDATA_W;
  localparam int unsigned OUT_TDATA_W = lcbc_pkg::OUT_TDATA_W;
  localparam int unsigned CNT_W       = lcbc_pkg::CNT_W;
  localparam int unsigned MAX_DIG     = lcbc_pkg::MAX_DIGITS_DEF;
  // bit row, one scan cell per digit, output register
  localparam int unsigned LATENCY     = 63 + MAX_DIG + 1;
  localparam int unsigned RANDOM_CNT  = 1200;
  localparam int unsigned HOLD_LEN    = 400;
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic                   clk_i  = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;   // [62:0] card_number, [63] zero
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;   // [1:0] brand, [2] luhn_ok, [7:3] digit_count

  logic [DATA_W-1:0] card_q[$];     // card numbers waiting to be sent
  lcbc_pkg::result_t verdict_q[$];  // expected results in order
  int unsigned       total_items;
  int unsigned       items_sent;
  int unsigned       results_seen;
  int unsigned       mismatch_cnt;
  int unsigned       branded_cnt;
  int unsigned       luhn_pass_cnt;
  int unsigned       hold_left;
  bit                hold_done;
  int unsigned       cycle_cnt;

  luhn_card_brand_check #(
    .MAX_DIGITS(MAX_DIG)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // expected verdict for one card number
  function automatic lcbc_pkg::result_t card_verdict(input logic [DATA_W-1:0] num);
    logic [63:0]       rest;
    int unsigned       digs[MAX_DIG];
    int unsigned       cnt, sum, lead, d, t, i;
    lcbc_pkg::result_t r;
    rest = {1'b0, num};
    cnt  = 0;
    sum  = 0;
    lead = 0;
    for (i = 0; i < MAX_DIG; i++) begin
      if (rest == 0) break;
      d       = int'(rest % 64'd10);
      rest    = rest / 64'd10;
      digs[i] = d;
      cnt++;
      if (i % 2 == 1) begin
        // every second digit from the right is doubled, digits of the product added
        t = 2 * d;
        if (t >= 10) t -= 9;
        sum += t;
      end else begin
        sum += d;
      end
    end
    if (cnt >= 2) lead = digs[cnt-1] * 10 + digs[cnt-2];
    r.digit_count = cnt[CNT_W-1:0];
    r.luhn_ok     = (sum % 10 == 0);
    r.brand       = lcbc_pkg::BRAND_NONE;
    if (r.luhn_ok) begin
      if (cnt == 15) begin
        if (lead == 34 || lead == 37) r.brand = lcbc_pkg::BRAND_FIFTEEN;
      end else if (cnt == 13 || cnt == 16) begin
        if (lead >= 40 && lead < 50) r.brand = lcbc_pkg::BRAND_LEAD4;
        else if (cnt == 16 && lead >= 51 && lead < 56) r.brand = lcbc_pkg::BRAND_LEAD5;
      end
    end
    return r;
  endfunction

  // card number with given leading digits and length, check digit picked so the
  // luhn test passes or fails as asked
  function automatic logic [DATA_W-1:0] make_card(input int unsigned lead,
                                                  input int unsigned lead_len,
                                                  input int unsigned len,
                                                  input bit good);
    logic [63:0]       body;
    logic [DATA_W-1:0] cand;
    logic [DATA_W-1:0] pick;
    lcbc_pkg::result_t r;
    int unsigned       i, d;
    body = 64'(lead);
    for (i = lead_len; i + 1 < len; i++) body = body * 10 + $urandom_range(0, 9);
    pick = DATA_W'(body * 10);
    for (d = 0; d < 10; d++) begin
      cand = DATA_W'(body * 10 + d);
      r    = card_verdict(cand);
      if (r.luhn_ok == good) begin
        pick = cand;
        break;
      end
    end
    return pick;
  endfunction

  // idle percentages per third of the run: sender light, then receiver light, then none
  function automatic int unsigned tx_idle_pct(input int unsigned n);
    if (n < total_items / 3) return 18;
    if (n < 2 * total_items / 3) return 85;
    return 0;
  endfunction

  function automatic int unsigned rx_idle_pct(input int unsigned n);
    if (n < total_items / 3) return 85;
    if (n < 2 * total_items / 3) return 18;
    return 0;
  endfunction

  // driver: next card number goes out once the current one is taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      items_sent    <= 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (card_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct(items_sent)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, card_q.pop_front()};
        items_sent    <= items_sent + 1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // one long receiver hold-off late in the run, sender keeps pushing meanwhile
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && items_sent >= 5 * total_items / 6) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= rx_idle_pct(items_sent));
    end
  end

  // monitor: predict on input acceptance, check on output acceptance
  always @(posedge clk_i) begin
    lcbc_pkg::result_t got, want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) verdict_q.push_back(card_verdict(s_axis_tdata[62:0]));
      if (m_axis_tvalid && m_axis_tready) begin
        got = lcbc_pkg::result_t'(m_axis_tdata);
        results_seen++;
        if (verdict_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected result: brand %0d luhn %0d count %0d",
                     got.brand, got.luhn_ok, got.digit_count);
        end else begin
          want = verdict_q.pop_front();
          if (want.brand != lcbc_pkg::BRAND_NONE) branded_cnt++;
          if (want.luhn_ok) luhn_pass_cnt++;
          if (got !== want) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display({"result %0d: expected brand %0d luhn %0d count %0d,",
                        " got brand %0d luhn %0d count %0d"},
                       results_seen, want.brand, want.luhn_ok, want.digit_count,
                       got.brand, got.luhn_ok, got.digit_count);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, verdict_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    logic [63:0] noise;
    int unsigned i, kind, len, lead;
    bit          good;
    results_seen  = 0;
    mismatch_cnt  = 0;
    branded_cnt   = 0;
    luhn_pass_cnt = 0;
    cycle_cnt     = 0;

    // edges of the field: zero, single digits, widest values, 19 digits
    card_q.push_back('0);
    card_q.push_back(63'd1);
    card_q.push_back(63'd18);
    card_q.push_back({DATA_W{1'b1}});
    card_q.push_back(63'h4000_0000_0000_0000);
    card_q.push_back(63'd1000000000000000000);
    // each brand on its lengths
    card_q.push_back(make_card(34, 2, 15, 1'b1));
    card_q.push_back(make_card(37, 2, 15, 1'b1));
    card_q.push_back(make_card(4, 1, 13, 1'b1));
    card_q.push_back(make_card(4, 1, 16, 1'b1));
    card_q.push_back(make_card(51, 2, 16, 1'b1));
    card_q.push_back(make_card(55, 2, 16, 1'b1));
    // luhn failing on otherwise good numbers
    card_q.push_back(make_card(34, 2, 15, 1'b0));
    card_q.push_back(make_card(4, 1, 16, 1'b0));
    card_q.push_back(make_card(53, 2, 16, 1'b0));
    // leads just outside the ranges and wrong lengths
    card_q.push_back(make_card(56, 2, 16, 1'b1));
    card_q.push_back(make_card(50, 2, 16, 1'b1));
    card_q.push_back(make_card(36, 2, 15, 1'b1));
    card_q.push_back(make_card(39, 2, 15, 1'b1));
    card_q.push_back(make_card(34, 2, 16, 1'b1));
    card_q.push_back(make_card(4, 1, 15, 1'b1));
    card_q.push_back(make_card(4, 1, 14, 1'b1));
    card_q.push_back(make_card(51, 2, 13, 1'b1));
    card_q.push_back(make_card(4, 1, 19, 1'b1));

    // mostly well-formed numbers with random digits, the rest raw noise
    for (i = 0; i < RANDOM_CNT; i++) begin
      kind = $urandom_range(0, 9);
      good = ($urandom_range(0, 99) < 85);
      case (kind)
        0, 1: begin
          lead = ($urandom_range(0, 1) != 0) ? 34 : 37;
          card_q.push_back(make_card(lead, 2, 15, good));
        end
        2, 3: begin
          len = ($urandom_range(0, 1) != 0) ? 13 : 16;
          card_q.push_back(make_card(4, 1, len, good));
        end
        4, 5: begin
          card_q.push_back(make_card($urandom_range(51, 55), 2, 16, good));
        end
        6: begin
          card_q.push_back(make_card($urandom_range(10, 99), 2, $urandom_range(12, 18), good));
        end
        default: begin
          noise = {$urandom(), $urandom()};
          noise[63] = 1'b0;
          if ($urandom_range(0, 1) != 0) noise = noise >> $urandom_range(0, 62);
          card_q.push_back(noise[62:0]);
        end
      endcase
    end
    total_items = card_q.size();

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (results_seen < total_items) @(posedge clk_i);
    repeat (LATENCY + 16) @(posedge clk_i);

    $display("sent %0d card numbers through three idling phases and one long output stall",
             total_items);
    $display("checked %0d results: %0d passed luhn, %0d carried a brand",
             results_seen, luhn_pass_cnt, branded_cnt);
    if (mismatch_cnt == 0 && verdict_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatch_cnt, verdict_q.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[files.f]
sv/lcbc_pkg.sv
sv/lcbc_dabble_cell.sv
sv/lcbc_scan_cell.sv
sv/lcbc_skid.sv
sv/luhn_card_brand_check.sv
bench/luhn_card_brand_check_tb.sv
